>>> rtl/i2p_pkg.sv
`timescale 1ns / 1ps
// shared types, character codes and classification functions for the
// infix-to-postfix converter; no dependencies

package i2p_pkg;

	// default operator stack depth
	localparam int STACK_DEPTH_DEF = 32;

	// operator characters
	localparam logic [7:0] CH_POW   = 8'h5E; // '^'
	localparam logic [7:0] CH_DIV   = 8'h2F; // '/'
	localparam logic [7:0] CH_MUL   = 8'h2A; // '*'
	localparam logic [7:0] CH_ADD   = 8'h2B; // '+'
	localparam logic [7:0] CH_SUB   = 8'h2D; // '-'
	localparam logic [7:0] CH_EQ    = 8'h3D; // '='
	localparam logic [7:0] CH_LPAR  = 8'h28; // '('
	localparam logic [7:0] CH_RPAR  = 8'h29; // ')'
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// error codes carried by a result
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_OVF  = 2'd1;
	localparam logic [1:0] ERR_UNM  = 2'd2;

	// request from the sequencer to the output buffer
	typedef struct packed {
		logic       push;
		logic       fin;
		logic [7:0] char_v;
		logic [1:0] err;
	} ob_req_t;

	// operator precedence
	function automatic logic [2:0] prec_of(input logic [7:0] c);
		logic [2:0] p;
		unique case (c)
			CH_POW:         p = 3'd5;
			CH_MUL, CH_DIV: p = 3'd4;
			CH_ADD, CH_SUB: p = 3'd3;
			CH_EQ:          p = 3'd2;
			default:        p = 3'd1;
		endcase
		return p;
	endfunction

	// blank, tab through carriage return
	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// ascii letter or digit
	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

>>> rtl/i2p_stack.sv
`timescale 1ns / 1ps
// operator stack storage: single write port, registered read port
// uses i2p_pkg for the default depth

module i2p_stack
	import i2p_pkg::*;
#(
	parameter int DEPTH = STACK_DEPTH_DEF,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [7:0]       wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output logic [7:0]       rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/i2p_outbuf.sv
`timescale 1ns / 1ps
// result buffer: one pending result plus the output register, so the
// last-result mark is set once the item is known to be finished; uses i2p_pkg

module i2p_outbuf
	import i2p_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  ob_req_t    req,
	output logic       ok,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       is_last,
	output logic [1:0] error
);

	logic       o_valid_q;
	logic [7:0] o_char_q;
	logic       o_last_q;
	logic [1:0] o_err_q;
	logic       p_valid_q;
	logic [7:0] p_char_q;
	logic [1:0] p_err_q;
	logic       o_free;
	logic       move_o;
	logic       load_p;

	assign o_free = !o_valid_q || out_ready;
	assign ok     = !p_valid_q || o_free;
	// pending result moves out on a new push or on finish
	assign move_o = ok && p_valid_q && (req.push || req.fin);
	assign load_p = ok && req.push;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			p_valid_q <= 1'b0;
		end else begin
			if (move_o) begin
				o_valid_q <= 1'b1;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
			if (load_p) begin
				p_valid_q <= 1'b1;
			end else if (move_o) begin
				p_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (move_o) begin
			o_char_q <= p_char_q;
			o_err_q  <= p_err_q;
			o_last_q <= req.fin;
		end
		if (load_p) begin
			p_char_q <= req.char_v;
			p_err_q  <= req.err;
		end
	end

	assign out_valid = o_valid_q;
	assign out_char  = o_char_q;
	assign is_last   = o_last_q;
	assign error     = o_err_q;

endmodule

>>> rtl/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// top level of the infix-to-postfix converter: sequencer around the
// operator stack and the result buffer; uses i2p_pkg, i2p_stack, i2p_outbuf

// Shunting-yard converter taking one ASCII character, or an end-of-expression
// command, per transaction and giving postfix characters one per transaction,
// the last one of each input marked by is_last. The block takes one input at a
// time: in_ready is high only while the sequencer is idle. An input that looks
// at no stack entry goes through decode, then finish, an error result given at
// decode included. Otherwise decode is followed by a stack read, then a step per
// popped entry, a step to inspect an entry that stays on the stack or is the
// discarded '(', a step for the push of an operator and a step for an error
// result, and then finish. A ')' without matching '(' gives error 2 after the
// popped characters, a push onto a full stack gives error 1 and drops the
// character. There is no clearing pass after reset.

module infix_to_postfix_converter
	import i2p_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       is_last,
	output logic [1:0] error
);

	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_POP  = 6'b000100,
		S_PUSH = 6'b001000,
		S_ERR  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		MODE_FLUSH = 2'd0,
		MODE_CLOSE = 2'd1,
		MODE_OPER  = 2'd2
	} mode_t;

	state_t           st_q, st_d;
	mode_t            mode_q, mode_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [7:0]       ch_q, ch_d;
	logic [1:0]       err_q, err_d;
	logic [CNT_W-1:0] cnt_m1, cnt_m2;
	logic             we, re, pop;
	logic [IDX_W-1:0] raddr;
	logic [7:0]       wdata, top;
	ob_req_t          ob_req;
	logic             ob_ok;

	assign cnt_m1   = count_q - CNT_ONE;
	assign cnt_m2   = cnt_m1 - CNT_ONE;
	assign in_ready = (st_q == S_IDLE);

	// sequencer
	always_comb begin
		st_d    = st_q;
		mode_d  = mode_q;
		count_d = count_q;
		ch_d    = ch_q;
		err_d   = err_q;
		we      = 1'b0;
		re      = 1'b0;
		pop     = 1'b0;
		raddr   = cnt_m1[IDX_W-1:0];
		wdata   = ch_q;
		ob_req  = '0;
		unique case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					ch_d = ch;
					wdata = ch;
					st_d = S_FIN;
					if (cmd) begin
						mode_d = MODE_FLUSH;
						if (count_q != '0) begin
							re = 1'b1;
							st_d = S_RD;
						end
					end else if (is_space(ch)) begin
						st_d = S_FIN;
					end else if (is_alnum(ch)) begin
						ob_req.push = 1'b1;
						ob_req.char_v = ch;
						ob_req.err = ERR_NONE;
					end else if (ch == CH_LPAR) begin
						if (count_q < CNT_FULL) begin
							we = 1'b1;
							count_d = count_q + CNT_ONE;
						end else begin
							ob_req.push = 1'b1;
							ob_req.char_v = CH_NUL;
							ob_req.err = ERR_OVF;
						end
					end else begin
						mode_d = (ch == CH_RPAR) ? MODE_CLOSE : MODE_OPER;
						if (count_q != '0) begin
							re = 1'b1;
							st_d = S_RD;
						end else if (ch == CH_RPAR) begin
							ob_req.push = 1'b1;
							ob_req.char_v = CH_NUL;
							ob_req.err = ERR_UNM;
						end else begin
							we = 1'b1;
							count_d = count_q + CNT_ONE;
						end
					end
				end
			end
			S_RD: begin
				st_d = S_POP;
			end
			S_POP: begin
				if (ob_ok) begin
					unique case (mode_q)
						MODE_FLUSH: begin
							pop = 1'b1;
						end
						MODE_CLOSE: begin
							if (top == CH_LPAR) begin
								count_d = cnt_m1;
								st_d = S_FIN;
							end else begin
								pop = 1'b1;
							end
						end
						MODE_OPER: begin
							if (prec_of(ch_q) <= prec_of(top)) begin
								pop = 1'b1;
							end else begin
								st_d = S_PUSH;
							end
						end
						default: begin
							st_d = S_FIN;
						end
					endcase
				end
			end
			S_PUSH: begin
				if (count_q < CNT_FULL) begin
					we = 1'b1;
					count_d = count_q + CNT_ONE;
					st_d = S_FIN;
				end else begin
					err_d = ERR_OVF;
					st_d = S_ERR;
				end
			end
			S_ERR: begin
				ob_req.push = 1'b1;
				ob_req.char_v = CH_NUL;
				ob_req.err = err_q;
				if (ob_ok) begin
					st_d = S_FIN;
				end
			end
			S_FIN: begin
				ob_req.fin = 1'b1;
				if (ob_ok) begin
					st_d = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase

		// pop the top entry out and fetch the next one, if any
		if (pop) begin
			ob_req.push = 1'b1;
			ob_req.char_v = top;
			ob_req.err = ERR_NONE;
			count_d = cnt_m1;
			if (cnt_m1 != '0) begin
				re = 1'b1;
				raddr = cnt_m2[IDX_W-1:0];
			end else begin
				unique case (mode_q)
					MODE_CLOSE: begin
						err_d = ERR_UNM;
						st_d = S_ERR;
					end
					MODE_OPER: begin
						st_d = S_PUSH;
					end
					default: begin
						st_d = S_FIN;
					end
				endcase
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			count_q <= '0;
		end else begin
			st_q    <= st_d;
			count_q <= count_d;
		end
	end

	// item registers
	always_ff @(posedge clk) begin
		mode_q <= mode_d;
		ch_q   <= ch_d;
		err_q  <= err_d;
	end

	i2p_stack #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (top)
	);

	i2p_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (ob_req),
		.ok        (ob_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.is_last   (is_last),
		.error     (error)
	);

endmodule
